// File: hdl/lbbma_pkg.sv
// Package for the per-label bounding box unit: field widths, the store entry
// layout and the controller state type. No dependencies.
package lbbma_pkg;

    localparam int COORD_W            = 10;
    localparam int LABEL_W            = 12;
    localparam int OUT_W              = 11;
    localparam int SPAN_W             = COORD_W + 1;
    localparam int AREA_W             = 2 * SPAN_W;
    localparam int DEFAULT_NUM_LABELS = 4096;

    // One store entry per label
    typedef struct packed {
        logic               seen;
        logic [COORD_W-1:0] min_row;
        logic [COORD_W-1:0] max_row;
        logic [COORD_W-1:0] min_col;
        logic [COORD_W-1:0] max_col;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_WAIT,
        ST_SCAN,
        ST_DRAIN_A,
        ST_DRAIN_B,
        ST_EMIT
    } state_t;

endpackage

// File: hdl/label_bounding_box_max_area_unit.sv
// Per-label bounding box unit with largest-area search at end of frame.
// Depends on lbbma_pkg.
module label_bounding_box_max_area_unit
    import lbbma_pkg::*;
#(
    parameter int NUM_LABELS = DEFAULT_NUM_LABELS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [COORD_W-1:0]        row,
    input  logic [COORD_W-1:0]        column,
    input  logic signed [LABEL_W-1:0] label,
    input  logic                      last_pixel,
    output logic                      done,
    output logic [OUT_W-1:0]          top,
    output logic [OUT_W-1:0]          left,
    output logic [OUT_W-1:0]          bottom,
    output logic [OUT_W-1:0]          right
);

    // Usage
    // -----
    // Pixels of a frame arrive in raster order as command transactions: a
    // pixel is taken on a rising edge where start is high and busy is low.
    // While a frame streams in, busy stays low and one pixel per cycle is
    // taken. Each pixel does a read-modify-write of its label's entry in a
    // single store (one read port with registered data, one write port);
    // back-to-back pixels of the same label are covered by forwarding the
    // last written entry.
    // A pixel with last_pixel set ends the frame. busy then rises and the
    // unit sweeps the whole store, one entry per cycle, clearing seen bits
    // as it goes and tracking the largest box (multiply, then compare stage).
    // The result appears on top/left/bottom/right with done high for one
    // cycle, after the states ST_WAIT, ST_SCAN, ST_DRAIN_A, ST_DRAIN_B and
    // ST_EMIT; busy is already low while done is high.
    // The receiver cannot stall: done is a one-cycle strobe.
    // Reset: after rst_n is released the store is cleared in a pass over
    // every entry with busy high; no pixel is taken until it ends.

    localparam int IDX_W = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LABELS - 1);
    localparam int RED_STEPS = 8;   // 4096 / 16 labels leaves an 8-bit quotient

    // Store index: offset label reduced modulo NUM_LABELS by conditional
    // subtraction of shifted copies of the depth.
    function automatic logic [IDX_W-1:0] label_index(input logic [LABEL_W-1:0] lab);
        logic [31:0] v;
        logic [31:0] d;
        v = {{(32-LABEL_W){1'b0}}, ~lab[LABEL_W-1], lab[LABEL_W-2:0]};
        for (int k = RED_STEPS - 1; k >= 0; k--) begin
            d = 32'(NUM_LABELS) << k;
            if (v >= d) begin
                v = v - d;
            end
        end
        return v[IDX_W-1:0];
    endfunction

    // Store
    entry_t mem [NUM_LABELS];

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;

    logic [IDX_W-1:0]  rd_addr;
    entry_t            rd_data_reg;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;

    // Pixel update stage
    logic              accept;
    logic              p1_valid_reg;
    logic [IDX_W-1:0]  p1_idx_reg;
    logic [COORD_W-1:0] p1_row_reg;
    logic [COORD_W-1:0] p1_col_reg;
    logic              fwd_valid_reg;
    logic [IDX_W-1:0]  fwd_idx_reg;
    entry_t            fwd_data_reg;
    entry_t            base;
    entry_t            upd;

    // Scan stages
    logic              sa_valid_reg;
    logic [SPAN_W-1:0] h_span;
    logic [SPAN_W-1:0] w_span;
    logic              sb_valid_reg;
    logic [AREA_W-1:0] sb_area_reg;
    entry_t            sb_box_reg;
    logic              found_reg;
    logic [AREA_W-1:0] best_area_reg;
    entry_t            best_box_reg;
    logic              take;

    logic              done_reg;
    logic [OUT_W-1:0]  top_reg, left_reg, bottom_reg, right_reg;

    assign busy   = (state_reg != ST_RUN);
    assign accept = start && !busy;

    // Controller
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_CLEAR: begin
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == LAST_IDX) begin
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (accept && last_pixel) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                cnt_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == LAST_IDX) begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN_A;
                end
            end
            ST_DRAIN_A: state_next = ST_DRAIN_B;
            ST_DRAIN_B: state_next = ST_EMIT;
            ST_EMIT:    state_next = ST_RUN;
            default:    state_next = ST_CLEAR;
        endcase
    end

    // Store ports: pixel update has the write port; clear and scan sweeps
    // write a cleared entry at the sweep address.
    assign rd_addr = (state_reg == ST_SCAN) ? cnt_reg : label_index(label);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg;
        wr_data = '0;
        if (p1_valid_reg) begin
            wr_en   = 1'b1;
            wr_addr = p1_idx_reg;
            wr_data = upd;
        end else if (state_reg == ST_CLEAR || state_reg == ST_SCAN) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Pixel read-modify-write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            p1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg  <= accept;
            fwd_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_idx_reg   <= label_index(label);
        p1_row_reg   <= row;
        p1_col_reg   <= column;
        fwd_idx_reg  <= p1_idx_reg;
        fwd_data_reg <= upd;
    end

    // Entry written on the previous edge is not yet visible in read data
    assign base = (fwd_valid_reg && fwd_idx_reg == p1_idx_reg) ? fwd_data_reg : rd_data_reg;

    always_comb
    begin
        upd = base;
        if (!base.seen) begin
            upd.seen    = 1'b1;
            upd.min_row = p1_row_reg;
            upd.max_row = p1_row_reg;
            upd.min_col = p1_col_reg;
            upd.max_col = p1_col_reg;
        end else begin
            if (p1_row_reg < base.min_row) upd.min_row = p1_row_reg;
            if (p1_row_reg > base.max_row) upd.max_row = p1_row_reg;
            if (p1_col_reg < base.min_col) upd.min_col = p1_col_reg;
            if (p1_col_reg > base.max_col) upd.max_col = p1_col_reg;
        end
    end

    // Scan: stage A forms the area, stage B compares against the best so far.
    // Ascending order plus ">=" on the left column gives full ties to the
    // larger label.
    assign h_span = {1'b0, rd_data_reg.max_row} - {1'b0, rd_data_reg.min_row} + SPAN_W'(1);
    assign w_span = {1'b0, rd_data_reg.max_col} - {1'b0, rd_data_reg.min_col} + SPAN_W'(1);

    always_comb
    begin
        take = 1'b0;
        if (!found_reg) begin
            take = 1'b1;
        end else if (sb_area_reg != best_area_reg) begin
            take = sb_area_reg > best_area_reg;
        end else if (sb_box_reg.min_row != best_box_reg.min_row) begin
            take = sb_box_reg.min_row > best_box_reg.min_row;
        end else begin
            take = sb_box_reg.min_col >= best_box_reg.min_col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sa_valid_reg <= 1'b0;
            sb_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            sa_valid_reg <= (state_reg == ST_SCAN);
            sb_valid_reg <= sa_valid_reg && rd_data_reg.seen;
            done_reg     <= (state_reg == ST_EMIT);
            if (state_reg == ST_WAIT) begin
                found_reg <= 1'b0;
            end else if (sb_valid_reg && take) begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sb_area_reg <= AREA_W'(h_span) * AREA_W'(w_span);
        sb_box_reg  <= rd_data_reg;
        if (sb_valid_reg && take) begin
            best_area_reg <= sb_area_reg;
            best_box_reg  <= sb_box_reg;
        end
        if (state_reg == ST_EMIT) begin
            top_reg    <= {1'b0, best_box_reg.min_row} + OUT_W'(1);
            left_reg   <= {1'b0, best_box_reg.min_col} + OUT_W'(1);
            bottom_reg <= {1'b0, best_box_reg.max_row} + OUT_W'(1);
            right_reg  <= {1'b0, best_box_reg.max_col} + OUT_W'(1);
        end
    end

    assign done   = done_reg;
    assign top    = top_reg;
    assign left   = left_reg;
    assign bottom = bottom_reg;
    assign right  = right_reg;

endmodule

// File: tb/tb_label_bounding_box_max_area_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for label_bounding_box_max_area_unit: frames of
// labelled pixels in, largest-area bounding box per frame checked out.
// Depends on lbbma_pkg and the unit itself.
module tb_label_bounding_box_max_area_unit
    import lbbma_pkg::*;
();

    localparam int NLAB       = DEFAULT_NUM_LABELS;
    localparam int SETTLE_CYC = 64;

    // One pixel transaction as the driver presents it
    typedef struct packed {
        logic [COORD_W-1:0]        row;
        logic [COORD_W-1:0]        col;
        logic signed [LABEL_W-1:0] label;
        logic                      last;
    } pixel_t;

    // One winning box, 1-based
    typedef struct packed {
        logic [OUT_W-1:0] top;
        logic [OUT_W-1:0] left;
        logic [OUT_W-1:0] bottom;
        logic [OUT_W-1:0] right;
    } box_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic [COORD_W-1:0]        row = '0;
    logic [COORD_W-1:0]        column = '0;
    logic signed [LABEL_W-1:0] label = '0;
    logic                      last_pixel = 1'b0;
    logic                      busy;
    logic                      done;
    logic [OUT_W-1:0]          top;
    logic [OUT_W-1:0]          left;
    logic [OUT_W-1:0]          bottom;
    logic [OUT_W-1:0]          right;

    pixel_t pending_pixels[$];
    box_t   expected_boxes[$];
    pixel_t next_pixel;
    int     idle_pct = 0;
    int     mismatches = 0;

    // Shadow of the per-label store
    bit                 label_seen[NLAB];
    logic [COORD_W-1:0] lo_row[NLAB];
    logic [COORD_W-1:0] hi_row[NLAB];
    logic [COORD_W-1:0] lo_col[NLAB];
    logic [COORD_W-1:0] hi_col[NLAB];

    label_bounding_box_max_area_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .row        (row),
        .column     (column),
        .label      (label),
        .last_pixel (last_pixel),
        .done       (done),
        .top        (top),
        .left       (left),
        .bottom     (bottom),
        .right      (right)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Folds one pixel into the shadow store. On a last pixel, scans every
    // label in ascending order for the largest box and returns 1 with it.
    // Ties: larger top row, then larger left column, then the later label.
    function automatic bit update_boxes(input pixel_t pix, output box_t box);
        logic [LABEL_W-1:0] slot;
        int                 idx;
        int                 best;
        bit                 found;
        bit                 take;
        longint unsigned    area;
        longint unsigned    best_area;
        slot = pix.label;
        slot[LABEL_W-1] = ~slot[LABEL_W-1];   // label + 2048
        idx = int'(slot) % NLAB;
        box = '0;
        if (!label_seen[idx])
        begin
            label_seen[idx] = 1'b1;
            lo_row[idx] = pix.row;
            hi_row[idx] = pix.row;
            lo_col[idx] = pix.col;
            hi_col[idx] = pix.col;
        end
        else
        begin
            if (pix.row < lo_row[idx]) lo_row[idx] = pix.row;
            if (pix.row > hi_row[idx]) hi_row[idx] = pix.row;
            if (pix.col < lo_col[idx]) lo_col[idx] = pix.col;
            if (pix.col > hi_col[idx]) hi_col[idx] = pix.col;
        end
        if (!pix.last)
            return 1'b0;

        found = 1'b0;
        best = 0;
        best_area = 0;
        for (int i = 0; i < NLAB; i++)
        begin
            if (!label_seen[i])
                continue;
            area = (longint'(hi_row[i]) - longint'(lo_row[i]) + 1)
                 * (longint'(hi_col[i]) - longint'(lo_col[i]) + 1);
            if (!found)
                take = 1'b1;
            else if (area != best_area)
                take = area > best_area;
            else if (lo_row[i] != lo_row[best])
                take = lo_row[i] > lo_row[best];
            else
                take = lo_col[i] >= lo_col[best];
            if (take)
            begin
                found = 1'b1;
                best = i;
                best_area = area;
            end
        end
        box.top    = {1'b0, lo_row[best]} + 11'd1;
        box.left   = {1'b0, lo_col[best]} + 11'd1;
        box.bottom = {1'b0, hi_row[best]} + 11'd1;
        box.right  = {1'b0, hi_col[best]} + 11'd1;
        for (int i = 0; i < NLAB; i++)
            label_seen[i] = 1'b0;
        return 1'b1;
    endfunction

    // Driver: a new transaction goes out once the previous one is taken
    // (start high, busy low) or the line is free. start is assigned once
    // per edge so a back-to-back transaction keeps it high.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || !busy)
        begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                next_pixel = pending_pixels.pop_front();
                start      <= 1'b1;
                row        <= next_pixel.row;
                column     <= next_pixel.col;
                label      <= next_pixel.label;
                last_pixel <= next_pixel.last;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: results first, then the transaction taken at this edge
    always @(posedge clk)
    begin : monitor
        box_t want;
        box_t got;
        if (rst_n)
        begin
            if (done)
            begin
                got = '{top, left, bottom, right};
                if (expected_boxes.size() == 0)
                begin
                    $error("unexpected result: top %0d left %0d bottom %0d right %0d",
                           top, left, bottom, right);
                    mismatches++;
                end
                else
                begin
                    want = expected_boxes.pop_front();
                    if (got.top !== want.top)
                    begin
                        $error("top: expected %0d, got %0d", want.top, got.top);
                        mismatches++;
                    end
                    if (got.left !== want.left)
                    begin
                        $error("left: expected %0d, got %0d", want.left, got.left);
                        mismatches++;
                    end
                    if (got.bottom !== want.bottom)
                    begin
                        $error("bottom: expected %0d, got %0d", want.bottom, got.bottom);
                        mismatches++;
                    end
                    if (got.right !== want.right)
                    begin
                        $error("right: expected %0d, got %0d", want.right, got.right);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
            begin
                if (update_boxes('{row, column, label, last_pixel}, want))
                    expected_boxes.push_back(want);
            end
        end
    end

    task automatic add_pixel(input int r, input int c, input int lab, input bit fin);
        pixel_t pix;
        pix.row   = COORD_W'(r);
        pix.col   = COORD_W'(c);
        pix.label = LABEL_W'(lab);
        pix.last  = fin;
        pending_pixels.push_back(pix);
    endtask

    // Random frame: a small pool of labels, mostly clustered coordinates so
    // areas tie often, some spread over the full range, some stray labels.
    task automatic add_random_frame(output int npix);
        int  pool[6];
        int  pool_size;
        bit  clustered;
        int  base_r;
        int  base_c;
        int  r;
        int  c;
        int  lab;
        npix = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
        pool_size = $urandom_range(1, 6);
        for (int i = 0; i < pool_size; i++)
            pool[i] = $urandom_range(4095);
        clustered = $urandom_range(3) != 0;
        base_r = $urandom_range(1020);
        base_c = $urandom_range(1020);
        for (int p = 0; p < npix; p++)
        begin
            if (clustered)
            begin
                r = base_r + $urandom_range(3);
                c = base_c + $urandom_range(3);
            end
            else
            begin
                r = $urandom_range(1023);
                c = $urandom_range(1023);
            end
            lab = ($urandom_range(9) == 0) ? $urandom_range(4095)
                                           : pool[$urandom_range(pool_size - 1)];
            add_pixel(r, c, lab, p == npix - 1);
        end
    endtask

    // Random part split over three idle settings
    task automatic run_random_phase(input int pct, input int min_items, input int min_frames);
        int items;
        int frames;
        int n;
        @(negedge clk);
        idle_pct = pct;
        items = 0;
        frames = 0;
        while (items < min_items || frames < min_frames)
        begin
            add_random_frame(n);
            items += n;
            frames++;
        end
        while (pending_pixels.size() != 0 || start)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        idle_pct = 33;

        // single pixel frame, most negative label, origin corner
        add_pixel(0, 0, -2048, 1'b1);
        // full-range box on the most positive label beats smaller ones
        add_pixel(1023, 1023, 2047, 1'b0);
        add_pixel(0, 0, 2047, 1'b0);
        add_pixel(5, 5, 0, 1'b0);
        add_pixel(7, 9, -1, 1'b1);
        // equal area, the lower box (larger top row) wins over a larger label
        add_pixel(0, 0, 100, 1'b0);
        add_pixel(1, 0, 100, 1'b0);
        add_pixel(5, 3, -100, 1'b0);
        add_pixel(6, 3, -100, 1'b1);
        // equal area and top, larger left column wins
        add_pixel(2, 8, -7, 1'b0);
        add_pixel(2, 9, -7, 1'b0);
        add_pixel(2, 0, 7, 1'b0);
        add_pixel(2, 1, 7, 1'b1);
        // identical boxes, the larger label wins; last pixel grows a seen label
        add_pixel(3, 3, 5, 1'b0);
        add_pixel(3, 3, -5, 1'b0);
        add_pixel(4, 4, -5, 1'b0);
        add_pixel(4, 4, 5, 1'b1);
        // last pixel lowers the minimum of an already seen label
        add_pixel(9, 9, 300, 1'b0);
        add_pixel(1, 2, 300, 1'b1);

        run_random_phase(33, 134, 14);
        run_random_phase(66, 134, 14);
        run_random_phase(0, 134, 14);

        while (expected_boxes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog: each frame end costs a scan over every label, and up to
    // 408 pixels could each end a frame
    initial
    begin
        #50_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
